/* hdl/table_driven_mealy_transducer_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef TABLE_DRIVEN_MEALY_TRANSDUCER_CORE_ASSERT_SVH
`define TABLE_DRIVEN_MEALY_TRANSDUCER_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle, outside reset.
`define TDMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle, outside reset.
`define TDMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define TDMT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tdmt_pkg.sv */
package tdmt_pkg;

    localparam int STATE_W    = 4;
    localparam int SYM_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int MAX_STATES = 1 << STATE_W;
    localparam int TRANS_AW   = STATE_W + SYM_W;
    localparam int TRANS_DEPTH = 1 << TRANS_AW;
    localparam int MAP_DEPTH  = 1 << BYTE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        ACT_MAP_BYTE     = 2'd0,
        ACT_WRITE_TRANS  = 2'd1,
        ACT_WRITE_ACCEPT = 2'd2,
        ACT_SYMBOL       = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE    = 2'd0,
        CFG_TRANSLATE_MODE = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]         action;
        logic [BYTE_W-1:0]  in_byte;
        logic [SYM_W-1:0]   symbol_index;
        logic               map_valid;
        logic [STATE_W-1:0] state_index;
        logic [STATE_W-1:0] next_state;
        logic [BYTE_W-1:0]  out_byte;
        logic               accept_flag;
        logic               word_last;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] translated_byte;
        logic              byte_valid;
        logic              word_done;
        logic              accepted;
        logic              bad_symbol;
    } t_out;

    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic [BYTE_W-1:0]  out_byte;
    } t_trans_entry;

endpackage

/* hdl/table_driven_mealy_transducer_core.sv */
// Channel | Direction | Handshake                    | Payload
// in      | request   | i_in_valid / o_in_stall      | i_in  (tdmt_pkg::t_in)
// out     | result    | o_out_valid / i_out_stall    | o_out (tdmt_pkg::t_out)
// cfg     | write     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One request, set-up or symbol, is taken every cycle while o_in_stall is low; a symbol
// is registered in the map and transition stages and its result in the output register.
// The rate is set by the transition memory read: its registered data feeds the next
// symbol's read address combinationally through the state forwarding path.
// Reset is synchronous and active low; it clears the map valid bits and accept flags.
// A stalled output holds back a symbol with a result and the requests behind it;
// bubbles upstream still fill while it waits.
module table_driven_mealy_transducer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tdmt_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tdmt_pkg::t_out                      o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tdmt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdmt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tdmt_pkg::*;

    // Configuration registers.
    logic [STATE_W-1:0] r_start_state;
    logic               r_translate;

    // Map stage (request registered together with its symbol map read).
    logic               r_b_valid;
    t_in                r_b_item;
    logic               r_b_map_ok;
    logic [SYM_W-1:0]   r_b_map_sym;

    // Transition stage.
    logic               r_c_valid;
    t_in                r_c_item;
    logic               r_c_hit;
    logic [STATE_W-1:0] r_c_state;
    logic               r_c_werr;
    t_trans_entry       r_c_trans;

    // Automaton state as of the last symbol that left the transition stage.
    logic [STATE_W-1:0]    r_state;
    logic                  r_werr;
    logic                  r_started;
    logic [MAX_STATES-1:0] r_accept_flags;

    // Tables.
    logic [MAP_DEPTH-1:0] r_map_valid;
    logic [SYM_W-1:0]     r_map_sym_mem [MAP_DEPTH];
    t_trans_entry         r_trans_mem [TRANS_DEPTH];

    logic  r_out_valid;
    t_out  r_out;

    logic               en_out;
    logic               c_is_sym;
    logic [STATE_W-1:0] c_state;
    logic               c_werr;
    logic               c_res;
    t_out               c_out;
    logic               c_go;
    logic               c_free;
    logic               b_go;
    logic               b_free;
    logic               in_accept;
    logic [STATE_W-1:0] f_state;
    logic               f_werr;
    logic               f_started;
    logic [STATE_W-1:0] b_state;
    logic               b_werr;
    logic [TRANS_AW-1:0] trans_raddr;
    logic [TRANS_AW-1:0] trans_waddr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_translate   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_STATE:    r_start_state <= i_cfg_data[STATE_W-1:0];
                CFG_TRANSLATE_MODE: r_translate   <= i_cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Transition stage: take the transition or keep the state on an unmapped byte.
    always_comb begin
        c_is_sym = (r_c_item.action == ACT_SYMBOL);
        c_state  = r_c_hit ? r_c_trans.next_state : r_c_state;
        c_werr   = r_c_werr | ~r_c_hit;
        c_res    = r_c_valid & c_is_sym & (r_translate | r_c_item.word_last);
        c_out.translated_byte = (r_translate & r_c_hit) ? r_c_trans.out_byte : '0;
        c_out.byte_valid      = r_translate & r_c_hit;
        c_out.word_done       = r_c_item.word_last;
        c_out.accepted        = r_c_item.word_last & r_accept_flags[c_state] & ~c_werr;
        c_out.bad_symbol      = r_c_item.word_last & c_werr;
    end

    always_comb begin
        en_out    = ~r_out_valid | ~i_out_stall;
        c_go      = r_c_valid & (~c_res | en_out);
        c_free    = ~r_c_valid | c_go;
        b_go      = r_b_valid & c_free;
        b_free    = ~r_b_valid | b_go;
        in_accept = i_in_valid & b_free;
    end

    assign o_in_stall = ~b_free;

    // The symbol in the map stage sees the state left by the symbol ahead of it.
    always_comb begin
        if (r_c_valid && c_is_sym) begin
            f_state   = c_state;
            f_werr    = c_werr;
            f_started = ~r_c_item.word_last;
        end else begin
            f_state   = r_state;
            f_werr    = r_werr;
            f_started = r_started;
        end
        b_state     = f_started ? f_state : r_start_state;
        b_werr      = f_started & f_werr;
        trans_raddr = {b_state, r_b_map_sym};
        trans_waddr = {r_b_item.state_index, r_b_item.symbol_index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_item   <= i_in;
            r_b_map_ok <= r_map_valid[i_in.in_byte];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= '0;
        end else if (in_accept && i_in.action == ACT_MAP_BYTE) begin
            r_map_valid[i_in.in_byte] <= i_in.map_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (i_in.action == ACT_MAP_BYTE) begin
                r_map_sym_mem[i_in.in_byte] <= i_in.symbol_index;
            end
            r_b_map_sym <= r_map_sym_mem[i_in.in_byte];
        end
    end

    // Writes land in the same stage as reads, so request order is kept.
    always_ff @(posedge i_clk) begin
        if (b_go) begin
            if (r_b_item.action == ACT_WRITE_TRANS) begin
                r_trans_mem[trans_waddr] <= {r_b_item.next_state, r_b_item.out_byte};
            end
            r_c_trans <= r_trans_mem[trans_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= b_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_c_item  <= r_b_item;
            r_c_hit   <= r_b_map_ok;
            r_c_state <= b_state;
            r_c_werr  <= b_werr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= '0;
            r_werr         <= 1'b0;
            r_started      <= 1'b0;
            r_accept_flags <= '0;
        end else if (c_go) begin
            if (c_is_sym) begin
                r_state   <= c_state;
                r_werr    <= c_werr;
                r_started <= ~r_c_item.word_last;
            end
            if (r_c_item.action == ACT_WRITE_ACCEPT) begin
                r_accept_flags[r_c_item.state_index] <= r_c_item.accept_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= c_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && c_res) begin
            r_out <= c_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hdl/tdmt_checker.sv */
`include "table_driven_mealy_transducer_core_assert.svh"

module tdmt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input tdmt_pkg::t_out                  o_out
);
    import tdmt_pkg::*;

    // A result that waits on a stall stays and keeps its value.
    `TDMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")

    // Reset empties the result register.
    `TDMT_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result present after reset")

    // With no result waiting, nothing inside can hold back a new request.
    `TDMT_ASSERT_IMPLY(a_no_stall_when_empty, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "input stalled with empty output")

    // A word with an unmapped byte is never accepted.
    `TDMT_ASSERT_IMPLY(a_bad_not_accepted, i_clk, i_rst_n, o_out_valid && o_out.bad_symbol, !o_out.accepted, "bad word reported as accepted")

endmodule

bind table_driven_mealy_transducer_core tdmt_checker u_tdmt_checker (.*);
